[rtl/rnlts_pkg.sv]
package rnlts_pkg;

	localparam int LOG_DEPTH    = 64;
	localparam int COMMAND_BITS = 64;
	localparam int NODE_ID_BITS = 8;
	localparam int TERM_BITS    = 64;
	localparam int IDX_BITS     = 32;
	localparam int ADDR_BITS    = $clog2(LOG_DEPTH);
	localparam int LEN_BITS     = $clog2(LOG_DEPTH + 1);
	localparam int ENTRY_BITS   = TERM_BITS + COMMAND_BITS;

	typedef enum logic [2:0] {
		ACT_VOTE, ACT_HEARTBEAT, ACT_APPEND, ACT_ELECT,
		ACT_LEADER, ACT_LEADER_APPEND, ACT_TRUNCATE, ACT_COMMIT
	} action_t;

	typedef enum logic [1:0] {
		ROLE_FOLLOWER, ROLE_CANDIDATE, ROLE_LEADER, ROLE_UNUSED
	} role_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_EXEC, OP_HDR, OP_HDR_CHK, OP_ENT, OP_ENT_CHK,
		OP_FIN, OP_COMMIT, OP_APPLY_RD, OP_APPLY_OUT, OP_APPLY_FAIL
	} op_t;

	typedef struct packed {
		op_t op;
	} ctrl_t;

	typedef struct packed {
		action_t act;
		logic    first;
		logic    last;
		logic    hdr_cmp;
		logic    ent_cmp;
		logic    apply_more;
		logic    apply_last;
		logic    out_free;
	} status_t;

endpackage

[rtl/rnlts_ram.sv]
module rnlts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/rnlts_datapath.sv]
module rnlts_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rnlts_pkg::ctrl_t       ctrl,
	output rnlts_pkg::status_t     status,
	input  logic [359:0]           in_data,
	input  logic [4:0]             in_user,
	input  logic                   in_last,
	input  logic                   cfg_valid,
	input  logic [7:0]             cfg_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [167:0]           out_data,
	output logic [2:0]             out_user,
	output logic                   out_last
);

	localparam int TB = rnlts_pkg::TERM_BITS;
	localparam int IB = rnlts_pkg::IDX_BITS;
	localparam int LB = rnlts_pkg::LEN_BITS;
	localparam int AB = rnlts_pkg::ADDR_BITS;
	localparam int CB = rnlts_pkg::COMMAND_BITS;
	localparam int NB = rnlts_pkg::NODE_ID_BITS;

	// Latched item
	rnlts_pkg::action_t act_q;
	logic          first_q, has_entry_q, last_q;
	logic [TB-1:0] msg_term_q, prev_term_q, entry_term_q;
	logic [NB-1:0] peer_q;
	logic [IB-1:0] log_index_q, ldr_commit_q, entry_index_q;
	logic [CB-1:0] command_q;

	// Node state
	logic [7:0]    own_id_q;
	logic [TB-1:0] term_q, term_n;
	rnlts_pkg::role_t role_q, role_n;
	logic          vv_q, vv_n;
	logic [NB-1:0] voted_q, voted_n;
	logic [LB-1:0] len_q, len_n, commit_q, commit_n, applied_q, applied_n;
	logic          failed_q, failed_n;
	logic [IB-1:0] expected_q, expected_n;

	// Result register
	logic          out_valid_q;
	logic [2:0]    out_kind_q;
	logic [TB-1:0] out_term_q;
	logic          out_ok_q, out_last_q;
	logic [IB-1:0] out_idx_q;
	logic [CB-1:0] out_cmd_q;
	rnlts_pkg::role_t out_role_q;

	logic          emit, ok, last_n;
	logic [CB-1:0] cmd_n;

	logic                    ram_we, ram_re;
	logic [AB-1:0]           ram_waddr, ram_raddr;
	logic [rnlts_pkg::ENTRY_BITS-1:0] ram_wdata, ram_rdata;
	logic [TB-1:0]           rd_term;
	logic [CB-1:0]           rd_cmd;

	logic [IB-1:0] len32, commit32;
	logic          term_ok, term_gt, idx_ok, out_free;

	assign rd_term  = ram_rdata[rnlts_pkg::ENTRY_BITS-1 -: TB];
	assign rd_cmd   = ram_rdata[CB-1:0];
	assign len32    = IB'(len_q);
	assign commit32 = IB'(commit_q);
	assign term_ok  = msg_term_q >= term_q;
	assign term_gt  = msg_term_q > term_q;
	assign idx_ok   = (entry_index_q != '0) && (entry_index_q == expected_q);
	assign out_free = !out_valid_q || out_ready;

	assign status.act        = act_q;
	assign status.first      = first_q;
	assign status.last       = last_q;
	assign status.hdr_cmp    = term_ok && (log_index_q <= len32) && (log_index_q != '0);
	assign status.ent_cmp    = has_entry_q && !failed_q && idx_ok && (entry_index_q <= len32);
	assign status.apply_more = applied_q < commit_q;
	assign status.apply_last = (applied_q + LB'(1)) >= commit_q;
	assign status.out_free   = out_free;

	rnlts_ram #(.WIDTH(rnlts_pkg::ENTRY_BITS), .DEPTH(rnlts_pkg::LOG_DEPTH)) u_log (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		term_n     = term_q;
		role_n     = role_q;
		vv_n       = vv_q;
		voted_n    = voted_q;
		len_n      = len_q;
		commit_n   = commit_q;
		applied_n  = applied_q;
		failed_n   = failed_q;
		expected_n = expected_q;
		emit       = 1'b0;
		ok         = 1'b0;
		last_n     = 1'b1;
		cmd_n      = '0;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_waddr  = AB'(len_q);
		ram_raddr  = AB'(log_index_q - IB'(1));
		ram_wdata  = {entry_term_q, command_q};
		case (ctrl.op)
			rnlts_pkg::OP_EXEC: begin
				emit = 1'b1;
				case (act_q)
					rnlts_pkg::ACT_VOTE: begin
						if (term_ok) begin
							if (term_gt) begin
								term_n = msg_term_q;
								role_n = rnlts_pkg::ROLE_FOLLOWER;
								vv_n   = 1'b0;
							end
							if (!vv_n || voted_q == peer_q) begin
								vv_n    = 1'b1;
								voted_n = peer_q;
								role_n  = rnlts_pkg::ROLE_FOLLOWER;
								ok      = 1'b1;
							end
						end
					end
					rnlts_pkg::ACT_HEARTBEAT: begin
						if (term_ok) begin
							ok     = 1'b1;
							role_n = rnlts_pkg::ROLE_FOLLOWER;
							if (term_gt) begin
								term_n = msg_term_q;
								vv_n   = 1'b0;
							end
						end
					end
					rnlts_pkg::ACT_ELECT: begin
						term_n  = term_q + TB'(1);
						role_n  = rnlts_pkg::ROLE_CANDIDATE;
						voted_n = own_id_q[NB-1:0];
						vv_n    = 1'b1;
						ok      = 1'b1;
					end
					rnlts_pkg::ACT_LEADER: begin
						role_n = rnlts_pkg::ROLE_LEADER;
						ok     = 1'b1;
					end
					rnlts_pkg::ACT_LEADER_APPEND: begin
						if (len_q < LB'(rnlts_pkg::LOG_DEPTH)) begin
							ram_we    = 1'b1;
							ram_wdata = {term_q, command_q};
							len_n     = len_q + LB'(1);
							ok        = 1'b1;
						end
					end
					rnlts_pkg::ACT_TRUNCATE: begin
						if (log_index_q != '0 && log_index_q > commit32 &&
							log_index_q <= len32) begin
							len_n = LB'(log_index_q - IB'(1));
							ok    = 1'b1;
						end
					end
					default: begin
						emit = 1'b1;
					end
				endcase
			end
			rnlts_pkg::OP_HDR: begin
				if (term_ok) begin
					role_n = rnlts_pkg::ROLE_FOLLOWER;
					if (term_gt) begin
						term_n = msg_term_q;
						vv_n   = 1'b0;
					end
				end
				failed_n   = !term_ok || (log_index_q > len32);
				expected_n = log_index_q + IB'(1);
				ram_re     = status.hdr_cmp;
			end
			rnlts_pkg::OP_HDR_CHK: begin
				if (rd_term != prev_term_q) begin
					len_n    = LB'(log_index_q - IB'(1));
					failed_n = 1'b1;
					if (commit_q > len_n) commit_n = len_n;
					if (applied_q > len_n) applied_n = len_n;
				end
			end
			rnlts_pkg::OP_ENT: begin
				ram_raddr = AB'(entry_index_q - IB'(1));
				if (has_entry_q && !failed_q) begin
					if (!idx_ok) begin
						failed_n = 1'b1;
					end else if (entry_index_q <= len32) begin
						ram_re = 1'b1;
					end else if (entry_index_q == len32 + IB'(1) &&
						len_q < LB'(rnlts_pkg::LOG_DEPTH)) begin
						ram_we     = 1'b1;
						len_n      = len_q + LB'(1);
						expected_n = expected_q + IB'(1);
					end else begin
						failed_n = 1'b1;
					end
				end
			end
			rnlts_pkg::OP_ENT_CHK: begin
				ram_waddr  = AB'(entry_index_q - IB'(1));
				expected_n = expected_q + IB'(1);
				if (rd_term != entry_term_q) begin
					// Conflicting entry: drop it and everything after, then rewrite it.
					if (commit_q > LB'(entry_index_q - IB'(1)))
						commit_n = LB'(entry_index_q - IB'(1));
					if (applied_q > LB'(entry_index_q - IB'(1)))
						applied_n = LB'(entry_index_q - IB'(1));
					ram_we = 1'b1;
					len_n  = LB'(entry_index_q);
				end
			end
			rnlts_pkg::OP_FIN: begin
				emit = 1'b1;
				ok   = !failed_q;
				if (!failed_q && ldr_commit_q > commit32)
					commit_n = (ldr_commit_q < len32) ? LB'(ldr_commit_q) : len_q;
			end
			rnlts_pkg::OP_COMMIT: begin
				commit_n = (log_index_q < len32) ? LB'(log_index_q) : len_q;
			end
			rnlts_pkg::OP_APPLY_RD: begin
				ram_re    = 1'b1;
				ram_raddr = AB'(applied_q);
			end
			rnlts_pkg::OP_APPLY_OUT: begin
				emit      = 1'b1;
				ok        = 1'b1;
				cmd_n     = rd_cmd;
				last_n    = status.apply_last;
				applied_n = applied_q + LB'(1);
			end
			rnlts_pkg::OP_APPLY_FAIL: begin
				emit = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == rnlts_pkg::OP_LOAD) begin
			act_q         <= rnlts_pkg::action_t'(in_user[2:0]);
			has_entry_q   <= in_user[3];
			first_q       <= in_user[4];
			last_q        <= in_last;
			msg_term_q    <= in_data[63:0];
			peer_q        <= in_data[64 +: NB];
			log_index_q   <= in_data[103:72];
			prev_term_q   <= in_data[167:104];
			ldr_commit_q  <= in_data[199:168];
			entry_index_q <= in_data[231:200];
			entry_term_q  <= in_data[295:232];
			command_q     <= in_data[296 +: CB];
		end
		if (emit) begin
			out_kind_q <= act_q;
			out_term_q <= term_n;
			out_ok_q   <= ok;
			out_idx_q  <= IB'(len_n);
			out_cmd_q  <= cmd_n;
			out_role_q <= role_n;
			out_last_q <= last_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q    <= '0;
			term_q      <= '0;
			role_q      <= rnlts_pkg::ROLE_FOLLOWER;
			vv_q        <= 1'b0;
			voted_q     <= '0;
			len_q       <= '0;
			commit_q    <= '0;
			applied_q   <= '0;
			failed_q    <= 1'b0;
			expected_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) own_id_q <= cfg_data;
			term_q      <= term_n;
			role_q      <= role_n;
			vv_q        <= vv_n;
			voted_q     <= voted_n;
			len_q       <= len_n;
			commit_q    <= commit_n;
			applied_q   <= applied_n;
			failed_q    <= failed_n;
			expected_q  <= expected_n;
			if (emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_user  = out_kind_q;
	assign out_last  = out_last_q;
	assign out_data  = {5'd0, out_role_q, out_cmd_q, out_idx_q, out_ok_q, out_term_q};

endmodule

[rtl/rnlts_ctrl.sv]
module rnlts_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  rnlts_pkg::status_t   status,
	output rnlts_pkg::ctrl_t     ctrl
);

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_EXEC, S_HDR, S_HDR_CHK, S_ENT, S_ENT_CHK, S_FIN,
		S_COMMIT, S_APPLY_RD, S_APPLY_OUT
	} state_t;

	state_t state_q, state_n;
	logic   emitted_q, emitted_n;

	always_comb begin
		state_n   = state_q;
		emitted_n = emitted_q;
		ctrl.op   = rnlts_pkg::OP_NONE;
		in_ready  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctrl.op = rnlts_pkg::OP_LOAD;
					state_n = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (status.act)
					rnlts_pkg::ACT_APPEND: state_n = status.first ? S_HDR : S_ENT;
					rnlts_pkg::ACT_COMMIT: state_n = S_COMMIT;
					default:               state_n = S_EXEC;
				endcase
			end
			S_EXEC: begin
				if (status.out_free) begin
					ctrl.op = rnlts_pkg::OP_EXEC;
					state_n = S_IDLE;
				end
			end
			S_HDR: begin
				ctrl.op = rnlts_pkg::OP_HDR;
				state_n = status.hdr_cmp ? S_HDR_CHK : S_ENT;
			end
			S_HDR_CHK: begin
				ctrl.op = rnlts_pkg::OP_HDR_CHK;
				state_n = S_ENT;
			end
			S_ENT: begin
				ctrl.op = rnlts_pkg::OP_ENT;
				state_n = status.ent_cmp ? S_ENT_CHK : S_FIN;
			end
			S_ENT_CHK: begin
				ctrl.op = rnlts_pkg::OP_ENT_CHK;
				state_n = S_FIN;
			end
			S_FIN: begin
				// Only the last item of an append request gives a reply.
				if (!status.last) begin
					state_n = S_IDLE;
				end else if (status.out_free) begin
					ctrl.op = rnlts_pkg::OP_FIN;
					state_n = S_IDLE;
				end
			end
			S_COMMIT: begin
				ctrl.op   = rnlts_pkg::OP_COMMIT;
				emitted_n = 1'b0;
				state_n   = S_APPLY_RD;
			end
			S_APPLY_RD: begin
				if (status.apply_more) begin
					ctrl.op = rnlts_pkg::OP_APPLY_RD;
					state_n = S_APPLY_OUT;
				end else if (emitted_q) begin
					state_n = S_IDLE;
				end else if (status.out_free) begin
					ctrl.op = rnlts_pkg::OP_APPLY_FAIL;
					state_n = S_IDLE;
				end
			end
			S_APPLY_OUT: begin
				if (status.out_free) begin
					ctrl.op   = rnlts_pkg::OP_APPLY_OUT;
					emitted_n = 1'b1;
					state_n   = status.apply_last ? S_IDLE : S_APPLY_RD;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			emitted_q <= 1'b0;
		end else begin
			state_q   <= state_n;
			emitted_q <= emitted_n;
		end
	end

endmodule

[rtl/raft_node_log_and_term_state_top.sv]
// Raft node core holding the current term, role, vote and a 64-entry log of term and command
// words in one single-port-write, registered-read memory. Each item is accepted, decoded, then
// run step by step, where a log compare adds a step for the memory read (append header and
// entry checks). Mark committed walks the log, reading and then releasing each command in turn.
// The next item is accepted while a reply waits on the output.
module raft_node_log_and_term_state_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// msg_term, peer_id, log_index, prev_term, ldr_commit, entry_index, entry_term,
	// command_word
	input  logic [359:0] s_tdata,
	// action, has_entry, first_item
	input  logic [4:0]   s_tuser,
	// last_item
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// reply_term, success, reply_index, applied_command, node_role, zero padding
	output logic [167:0] m_tdata,
	// reply_kind
	output logic [2:0]   m_tuser,
	// last_of_run
	output logic         m_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_data
);

	rnlts_pkg::ctrl_t   ctrl;
	rnlts_pkg::status_t status;

	assign cfg_ready = 1'b1;

	rnlts_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.status  (status),
		.ctrl    (ctrl)
	);

	rnlts_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.status   (status),
		.in_data  (s_tdata),
		.in_user  (s_tuser),
		.in_last  (s_tlast),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (m_tdata),
		.out_user (m_tuser),
		.out_last (m_tlast)
	);

endmodule
